>>> hdl/afb_pkg.sv
// Package for the activation forward/backward unit: kinds, item sideband, sigmoid table builder.
package afb_pkg;

   // default sigmoid table size (segments over [-8, 8))
   localparam int TABLE_ENTRIES_DEF = 256;

   // Q4.12 one
   localparam logic [12:0] ONE_Q12 = 13'd4096;

   // activation kinds; the unused code behaves as identity
   typedef enum logic [1:0] {
      KIND_SIGMOID  = 2'd0,
      KIND_TANH     = 2'd1,
      KIND_IDENTITY = 2'd2
   } kind_type;

   // fields that ride along with an item through the pipeline
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [31:0] up;
      logic signed [31:0] prior;
      kind_type           kind;
   } side_type;

   // restoring divide, used only while building the constant table
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^(-num/den) in Q30: series at a sixteenth of the argument, then squared four times
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] g;
      logic [63:0] term;
      logic [63:0] sum;
      logic        stop;
      g    = udiv((num << 30) + (den << 3), den << 4);
      sum  = 64'd1 << 30;
      term = 64'd1 << 30;
      stop = 1'b0;
      for (int i = 1; i <= 24; i++) begin
         if (!stop) begin
            term = udiv((term * g) >> 30, 64'(i));
            if (term == 64'd0) begin
               stop = 1'b1;
            end else if (i[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      for (int r = 0; r < 4; r++) begin
         sum = (sum * sum + (64'd1 << 29)) >> 30;
      end
      return sum;
   endfunction

   // table entry k of n: round(4096 * sigmoid(-8 + 16*k/n))
   function automatic logic [12:0] sig_entry(input int k, input int n);
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] mag;
      logic [63:0] e;
      logic [63:0] d;
      logic [63:0] val;
      pos = 64'(16 * k);
      neg = 64'(8 * n);
      mag = (pos >= neg) ? pos - neg : neg - pos;
      e   = exp_neg_q30(mag, 64'(n));
      d   = (64'd1 << 30) + e;
      if (pos >= neg) begin
         val = udiv((64'd1 << 42) + (d >> 1), d);
      end else begin
         val = udiv((e << 12) + (d >> 1), d);
      end
      return val[12:0];
   endfunction

endpackage

>>> hdl/activation_forward_backward.sv
// Activation forward/backward top level: kind register and the two pipeline sections.
//
// Streams one element per clock: each item takes x (Q4.12), an upstream gradient and a
// prior gradient (Q16.16) and returns y = f(x) with grad_prior + f'(x)*upstream_grad,
// saturated and flagged. Kind is sigmoid, tanh or identity (code 3 acts as identity).
// Throughput is one item per cycle while rsp_ready does not stall it; each item passes
// 8 register stages, and rsp_valid is the valid bit of the last. Four stages do the
// sigmoid lookup (index scaling, registered table read, slope multiply, interpolation)
// and four the gradient (result select, derivative multiply, gradient multiply,
// saturating add). A low rsp_ready stalls only the stages that hold items; the input
// stalls once all 8 are full. The sigmoid table holds TABLE_ENTRIES+1 constant points
// computed at elaboration. The kind is captured with each item; write csr only while
// the block is empty.
module activation_forward_backward #(
   parameter int TABLE_ENTRIES = afb_pkg::TABLE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_x_in,
   input  logic signed [31:0] req_upstream_grad,
   input  logic signed [31:0] req_grad_prior,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_y_out,
   output logic signed [31:0] rsp_grad_new,
   output logic               rsp_grad_saturated,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_write_data
);
   import afb_pkg::*;

   // activation kind register
   kind_type kind_ff;
   kind_type kind_in;

   always_comb begin
      kind_in = csr_write_en ? kind_type'(csr_write_data) : kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_SIGMOID;
      end else begin
         kind_ff <= kind_in;
      end
   end

   // item sideband entering the pipeline
   side_type req_side;

   always_comb begin
      req_side.x     = req_x_in;
      req_side.up    = req_upstream_grad;
      req_side.prior = req_grad_prior;
      req_side.kind  = kind_ff;
   end

   // sigmoid lookup section
   logic        mid_valid;
   logic        mid_ready;
   logic [12:0] mid_sig;
   side_type    mid_side;

   afb_sigm #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_sigm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_side   (req_side),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_sig   (mid_sig),
      .out_side  (mid_side)
   );

   // derivative and gradient section
   afb_grad u_grad (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_sig    (mid_sig),
      .in_side   (mid_side),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_y     (rsp_y_out),
      .out_grad  (rsp_grad_new),
      .out_sat   (rsp_grad_saturated)
   );

endmodule

>>> hdl/afb_sigm.sv
// Sigmoid lookup pipeline: table index, table read, slope product, interpolation.
module afb_sigm #(
   parameter int TABLE_ENTRIES = afb_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  afb_pkg::side_type in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [12:0]       out_sig,
   output afb_pkg::side_type out_side
);
   import afb_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int PROD_W = 17 + IDX_W;
   localparam int NSTG   = 4;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES);

   // constant sigmoid table, TABLE_ENTRIES+1 points
   logic [12:0] rom [TABLE_ENTRIES+1];
   for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_rom
      localparam logic [12:0] ENTRY = sig_entry(k, TABLE_ENTRIES);
      assign rom[k] = ENTRY;
   end

   // stage valids and per-stage load enables
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || out_ready;
      for (int s = NSTG - 2; s >= 0; s--) begin
         en[s] = !vld_ff[s] || en[s+1];
      end
      vld_in = {vld_ff[NSTG-2:0], in_valid};
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NSTG; s++) begin
            if (en[s]) vld_ff[s] <= vld_in[s];
         end
      end
   end

   // stage A: argument (2x for tanh), clamp to [-8, 8], scale to table position
   logic signed [17:0]  arg;
   logic [16:0]         ofs;
   logic [PROD_W-1:0]   pos;
   logic [IDX_W-1:0]    idx_a_in, idx_a_ff;
   logic [15:0]         frac_a_in, frac_a_ff;
   side_type            side_a_ff;

   always_comb begin
      if (in_side.kind == KIND_TANH) begin
         arg = {in_side.x[15], in_side.x, 1'b0};
      end else begin
         arg = {{2{in_side.x[15]}}, in_side.x};
      end
      if (arg < -18'sd32768) begin
         ofs = 17'd0;
      end else if (arg > 18'sd32768) begin
         ofs = 17'd65536;
      end else begin
         ofs = 17'(arg + 18'sd32768);
      end
      pos       = PROD_W'(ofs) * PROD_W'(TABLE_ENTRIES);
      idx_a_in  = IDX_W'(pos >> 16);
      frac_a_in = pos[15:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         idx_a_ff  <= idx_a_in;
         frac_a_ff <= frac_a_in;
         side_a_ff <= in_side;
      end
   end

   // stage B: read both neighbors; the last point reads itself twice
   logic [IDX_W-1:0] addr_lo, addr_hi;
   logic [12:0]      lo_b_ff, hi_b_ff;
   logic [15:0]      frac_b_ff;
   side_type         side_b_ff;

   always_comb begin
      if (idx_a_ff >= LAST_IDX) begin
         addr_lo = LAST_IDX;
         addr_hi = LAST_IDX;
      end else begin
         addr_lo = idx_a_ff;
         addr_hi = idx_a_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         lo_b_ff   <= rom[addr_lo];
         hi_b_ff   <= rom[addr_hi];
         frac_b_ff <= frac_a_ff;
         side_b_ff <= side_a_ff;
      end
   end

   // stage C: slope times fraction (table is monotone, slope never negative)
   logic [28:0] slope_c_in, slope_c_ff;
   logic [12:0] lo_c_ff;
   side_type    side_c_ff;

   assign slope_c_in = 29'(hi_b_ff - lo_b_ff) * 29'(frac_b_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         slope_c_ff <= slope_c_in;
         lo_c_ff    <= lo_b_ff;
         side_c_ff  <= side_b_ff;
      end
   end

   // stage D: round half up and add to the lower point
   logic [12:0] sig_d_in, sig_d_ff;
   side_type    side_d_ff;
   logic [28:0] slope_rnd;

   always_comb begin
      slope_rnd = slope_c_ff + 29'd32768;
      sig_d_in  = lo_c_ff + 13'(slope_rnd >> 16);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         sig_d_ff  <= sig_d_in;
         side_d_ff <= side_c_ff;
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_sig   = sig_d_ff;
   assign out_side  = side_d_ff;

endmodule

>>> hdl/afb_grad.sv
// Output and gradient pipeline: result select, derivative, gradient product, saturating sum.
module afb_grad (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [12:0]        in_sig,
   input  afb_pkg::side_type  in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [15:0] out_y,
   output logic signed [31:0] out_grad,
   output logic               out_sat
);
   import afb_pkg::*;

   localparam int NSTG = 4;

   // stage valids and per-stage load enables
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] en;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || out_ready;
      for (int s = NSTG - 2; s >= 0; s--) begin
         en[s] = !vld_ff[s] || en[s+1];
      end
      vld_in = {vld_ff[NSTG-2:0], in_valid};
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NSTG; s++) begin
            if (en[s]) vld_ff[s] <= vld_in[s];
         end
      end
   end

   // stage E: activation result
   logic signed [15:0] y_e_in, y_e_ff;
   side_type           side_e_ff;

   always_comb begin
      case (in_side.kind)
         KIND_SIGMOID: y_e_in = {3'b000, in_sig};
         KIND_TANH:    y_e_in = signed'({2'b00, in_sig, 1'b0}) - 16'sd4096;
         default:      y_e_in = in_side.x;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         y_e_ff    <= y_e_in;
         side_e_ff <= in_side;
      end
   end

   // stage F: derivative in Q24, taken from the result
   logic [24:0]        deriv_f_in, deriv_f_ff;
   logic signed [15:0] y_f_ff;
   side_type           side_f_ff;
   logic [25:0]        sig_prod;
   logic signed [27:0] tanh_sq;
   logic signed [13:0] y_t;
   logic [12:0]        y_lo;

   always_comb begin
      y_lo     = y_e_ff[12:0];
      sig_prod = 26'(y_lo) * 26'(ONE_Q12 - y_lo);
      // tanh result lies in [-4096, 4096]; square it as a signed value
      y_t      = y_e_ff[13:0];
      tanh_sq  = 28'(y_t) * 28'(y_t);
      case (side_e_ff.kind)
         KIND_SIGMOID: deriv_f_in = sig_prod[24:0];
         KIND_TANH:    deriv_f_in = 25'(28'sd16777216 - tanh_sq);
         default:      deriv_f_in = 25'd16777216;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         deriv_f_ff <= deriv_f_in;
         y_f_ff     <= y_e_ff;
         side_f_ff  <= side_e_ff;
      end
   end

   // stage G: derivative times upstream gradient
   logic signed [57:0] prod_g_in, prod_g_ff;
   logic signed [15:0] y_g_ff;
   logic signed [31:0] prior_g_ff;

   assign prod_g_in = 58'(signed'({1'b0, deriv_f_ff}) * side_f_ff.up);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         prod_g_ff  <= prod_g_in;
         y_g_ff     <= y_f_ff;
         prior_g_ff <= side_f_ff.prior;
      end
   end

   // stage H: round to Q16.16, accumulate, clamp to 32 bits
   logic signed [57:0] prod_rnd;
   logic signed [34:0] delta;
   logic signed [34:0] sum;
   logic signed [31:0] grad_h_in, grad_h_ff;
   logic               sat_h_in, sat_h_ff;
   logic signed [15:0] y_h_ff;

   always_comb begin
      prod_rnd = prod_g_ff + 58'sd8388608;
      delta    = {prod_rnd[57], prod_rnd[57:24]};
      sum      = {{3{prior_g_ff[31]}}, prior_g_ff} + delta;
      if (sum > 35'sd2147483647) begin
         grad_h_in = 32'sh7FFFFFFF;
         sat_h_in  = 1'b1;
      end else if (sum < -35'sd2147483648) begin
         grad_h_in = 32'sh80000000;
         sat_h_in  = 1'b1;
      end else begin
         grad_h_in = sum[31:0];
         sat_h_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         grad_h_ff <= grad_h_in;
         sat_h_ff  <= sat_h_in;
         y_h_ff    <= y_g_ff;
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_y     = y_h_ff;
   assign out_grad  = grad_h_ff;
   assign out_sat   = sat_h_ff;

endmodule

>>> bench/tb_top.sv
// Testbench for the activation forward/backward unit: stimulus, result prediction and checking.
`timescale 1ns / 100ps

module tb_top;
   import afb_pkg::*;

   localparam int POINTS = TABLE_ENTRIES_DEF;
   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 73;
   localparam int PHASE_COUNT = 10;
   localparam int SETTLE_CYCLES = 12;
   // kind code that the package leaves unnamed; the block treats it as identity
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // one predicted result item
   typedef struct {
      logic signed [15:0] y;
      logic signed [31:0] grad;
      logic               sat;
   } act_result_type;

   // predicts activation and gradient per accepted item and checks the outputs in order
   class grad_checker;
      longint         sigmoid_points[POINTS + 1];
      logic [1:0]     kind;
      act_result_type expected_results[$];
      int             errors;

      function new();
         kind   = KIND_SIGMOID;
         errors = 0;
         build_points();
      endfunction

      // arithmetic shift right, ties rounded up
      function longint round_shift(longint v, int sh);
         return (v + (longint'(1) << (sh - 1))) >>> sh;
      endfunction

      // e^(-num/den) in Q30: series at a sixteenth of the argument, squared four times
      function longint exp_q30(longint unsigned num, longint unsigned den);
         longint unsigned g;
         longint unsigned term;
         longint          sum;
         g    = ((num << 30) + 8 * den) / (16 * den);
         sum  = longint'(1) << 30;
         term = longint'(1) << 30;
         for (int i = 1; i <= 24; i++) begin
            term = ((term * g) >> 30) / longint'(i);
            if (term == 0)
               break;
            if (i % 2 == 1)
               sum = sum - longint'(term);
            else
               sum = sum + longint'(term);
         end
         for (int r = 0; r < 4; r++) begin
            sum = longint'((longint'(sum) * longint'(sum) + (longint'(1) << 29)) >>> 30);
         end
         return sum;
      endfunction

      // sigmoid sample points over [-8, 8], rounded to Q12
      function void build_points();
         longint num;
         longint e;
         longint d;
         for (int k = 0; k <= POINTS; k++) begin
            num = 16 * longint'(k) - 8 * longint'(POINTS);
            e   = exp_q30((num < 0) ? -num : num, POINTS);
            d   = (longint'(1) << 30) + e;
            if (num >= 0)
               sigmoid_points[k] = ((longint'(1) << 42) + d / 2) / d;
            else
               sigmoid_points[k] = (4096 * e + d / 2) / d;
         end
      endfunction

      // interpolated sigmoid of a Q4.12 value, clamped to the table span
      function longint sigmoid_q12(longint v);
         longint p;
         longint idx;
         longint fr;
         longint a;
         longint b;
         if (v < -32768)
            v = -32768;
         if (v > 32768)
            v = 32768;
         p   = (v + 32768) * POINTS;
         idx = p >>> 16;
         fr  = p & 64'hFFFF;
         if (idx >= POINTS)
            return sigmoid_points[POINTS];
         a = sigmoid_points[idx];
         b = sigmoid_points[idx + 1];
         return a + round_shift((b - a) * fr, 16);
      endfunction

      function void set_kind(logic [1:0] k);
         kind = k;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // accepted input item: compute y, derivative and the saturated gradient sum
      function void note_item(logic signed [15:0] x_in, logic signed [31:0] up_in,
                              logic signed [31:0] prior_in);
         longint         x;
         longint         y;
         longint         deriv;
         longint         sum;
         act_result_type res;
         x = x_in;
         case (kind)
            KIND_SIGMOID: begin
               y     = sigmoid_q12(x);
               deriv = y * (4096 - y);
            end
            KIND_TANH: begin
               y     = 2 * sigmoid_q12(2 * x) - 4096;
               deriv = (longint'(1) << 24) - y * y;
            end
            default: begin
               y     = x;
               deriv = longint'(1) << 24;
            end
         endcase
         sum     = longint'(prior_in) + round_shift(deriv * longint'(up_in), 24);
         res.sat = 1'b0;
         if (sum > 64'sd2147483647) begin
            sum     = 64'sd2147483647;
            res.sat = 1'b1;
         end else if (sum < -64'sd2147483648) begin
            sum     = -64'sd2147483648;
            res.sat = 1'b1;
         end
         res.y    = 16'(y);
         res.grad = 32'(sum);
         expected_results.push_back(res);
      endfunction

      // accepted result item against the oldest prediction
      function void check_result(logic signed [15:0] y, logic signed [31:0] grad,
                                 logic sat);
         act_result_type want;
         if (expected_results.size() == 0) begin
            $error("result item with no input item pending");
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (y !== want.y) begin
            $error("y_out mismatch: expected %0d, got %0d", want.y, y);
            errors++;
         end
         if (grad !== want.grad) begin
            $error("grad_new mismatch: expected %0d, got %0d", want.grad, grad);
            errors++;
         end
         if (sat !== want.sat) begin
            $error("grad_saturated mismatch: expected %0d, got %0d", want.sat, sat);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_x_in;
   logic signed [31:0] req_upstream_grad;
   logic signed [31:0] req_grad_prior;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_y_out;
   logic signed [31:0] rsp_grad_new;
   logic               rsp_grad_saturated;
   logic               csr_write_en;
   logic [1:0]         csr_write_data;

   grad_checker sb;
   int          cycles = 0;
   bit          no_gaps;
   bit          hold_request;
   bit          hold_done;

   activation_forward_backward dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_x_in           (req_x_in),
      .req_upstream_grad  (req_upstream_grad),
      .req_grad_prior     (req_grad_prior),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_y_out          (rsp_y_out),
      .rsp_grad_new       (rsp_grad_new),
      .rsp_grad_saturated (rsp_grad_saturated),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // input items accepted by the block
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_item(req_x_in, req_upstream_grad, req_grad_prior);
   end

   // result items accepted from the block
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_y_out, rsp_grad_new, rsp_grad_saturated);
   end

   // idle length: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver: ready bursts, random stalls, and one long hold-off on request
   initial begin
      int burst;
      int stall;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            @(negedge clock);
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            burst = $urandom_range(1, 40);
            @(negedge clock);
            rsp_ready = 1'b1;
            repeat (burst - 1) @(negedge clock);
            stall = pick_gap();
            if (stall > 0) begin
               @(negedge clock);
               rsp_ready = 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
         end
      end
   end

   // offer one item and hold it until accepted, then idle for a random gap unless no_gaps is set
   task automatic send_item(logic signed [15:0] x, logic signed [31:0] up,
                            logic signed [31:0] prior);
      int gap;
      @(negedge clock);
      req_valid         = 1'b1;
      req_x_in          = x;
      req_upstream_grad = up;
      req_grad_prior    = prior;
      do @(posedge clock); while (!req_ready);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop offering and wait until the block has returned everything
   task automatic drain_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_kind(logic [1:0] k);
      @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = k;
      @(posedge clock);
      sb.set_kind(k);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // directed items: range ends, tanh clamp points, saturation both ways
   task automatic directed_items();
      send_item(-16'sd32768, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_item(16'sd32767, 32'sh80000000, 32'sh80000000);
      send_item(16'sd0, 32'sh7FFFFFFF, 32'sd0);
      send_item(-16'sd16384, -32'sd1, 32'sd1);
      send_item(16'sd16384, 32'sd12345, -32'sd6789);
      send_item(-16'sd1, 32'sh00010000, -32'sd1);
   endtask

   // random item: mix of full range, near zero, clamp points and near-saturation sums
   task automatic random_item();
      logic signed [15:0] x;
      logic signed [31:0] up;
      logic signed [31:0] prior;
      int                 r;
      r = $urandom_range(0, 9);
      if (r < 5)
         x = 16'($urandom);
      else if (r < 8)
         x = 16'($urandom_range(0, 16383)) - 16'sd8192;
      else
         case ($urandom_range(0, 5))
            0: x = -16'sd32768;
            1: x = 16'sd32767;
            2: x = -16'sd16384;
            3: x = 16'sd16384;
            4: x = 16'sd16383;
            default: x = -16'sd16385;
         endcase
      r  = $urandom_range(0, 9);
      up = (r < 7) ? 32'($urandom) : 32'($urandom_range(0, 262143)) - 32'sd131072;
      r  = $urandom_range(0, 9);
      if (r < 6)
         prior = $urandom;
      else if (r < 8)
         prior = 32'sh7FFFFFFF - 32'($urandom_range(0, 1 << 24));
      else
         prior = 32'sh80000000 + 32'($urandom_range(0, 1 << 24));
      send_item(x, up, prior);
   endtask

   // main sequence
   initial begin
      logic [1:0] phase_kind;
      sb                = new();
      no_gaps           = 1'b0;
      hold_request      = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_x_in          = '0;
      req_upstream_grad = '0;
      req_grad_prior    = '0;
      csr_write_en      = 1'b0;
      csr_write_data    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, once per kind including the unused code
      write_kind(KIND_SIGMOID);
      directed_items();
      drain_block();
      write_kind(KIND_TANH);
      directed_items();
      drain_block();
      write_kind(KIND_IDENTITY);
      directed_items();
      drain_block();
      write_kind(KIND_UNUSED);
      directed_items();
      drain_block();

      // random phases, each under one kind
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0, 5: phase_kind = KIND_SIGMOID;
            1, 3, 7: phase_kind = KIND_TANH;
            2, 6: phase_kind = KIND_IDENTITY;
            4: phase_kind = KIND_UNUSED;
            default: phase_kind = 2'($urandom_range(0, 3));
         endcase
         write_kind(phase_kind);
         no_gaps      = (ph == 2 || ph == 6);
         hold_request = (ph >= 3);
         for (int n = 0; n < PHASE_ITEMS; n++)
            random_item();
         drain_block();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> activation_forward_backward.f
hdl/afb_pkg.sv
hdl/afb_sigm.sv
hdl/afb_grad.sv
hdl/activation_forward_backward.sv
bench/tb_top.sv
